// ===== rtl/text_console_cursor_engine_defines.svh =====
// Assertion macros used by the console engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TCCE_ASSERT_SAME(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error("console engine check failed");

// Next-cycle implication, checked outside reset
`define TCCE_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error("console engine check failed");

`endif

// ===== rtl/tcce_pkg.sv =====
`timescale 1ns / 1ps

package tcce_pkg;

    // Request codes
    typedef enum logic [1:0] {
        REQ_WRITE_CHAR  = 2'd0,
        REQ_SCROLL_UP   = 2'd1,
        REQ_SCROLL_DOWN = 2'd2,
        REQ_SELECT      = 2'd3
    } req_type_t;

    // Character codes with special handling
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [7:0] ATTR_RESET = 8'd7;

    // Input transaction payload
    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] console_index;
        logic [7:0] char_code;
    } in_item_t;

    // Result transaction payload
    typedef struct packed {
        logic        mem_write;
        logic [13:0] mem_cell;
        logic [7:0]  mem_char;
        logic [7:0]  mem_attr;
        logic [13:0] cursor_cell;
        logic [13:0] view_start_cell;
        logic [1:0]  shown_console;
    } out_item_t;

endpackage

// ===== rtl/text_console_cursor_engine.sv =====
`timescale 1ns / 1ps

// Text console cursor engine: several consoles sharing one video memory.
// Input channel in_valid / in_stall / in_data carries one request per
// transaction (write character, scroll up, scroll down, select console).
// Output channel out_valid / out_stall / out_data returns one result per
// request: an optional video memory cell write, plus the addressed
// console's cursor and view start and the displayed console afterwards.
// cfg_valid / cfg_ready / cfg_data writes the attribute byte (ready is
// always high); write it only while no request is in flight.
// An accepted request passes through an input register, then the
// combinational console update into the result register.
// Throughput is one request per cycle unless the receiver stalls; the
// per-console cursor and view registers are updated in the same cycle
// that the result is registered, so the following request sees them
// at once. When the receiver stalls the result is held and one further
// request is buffered in the input register before in_stall rises.
// Reset puts every cursor and view start at its console's region origin,
// selects console 0 and sets the attribute to 7.
module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_CELLS   = 2000,
    parameter int NUM_CONSOLES   = 4,
    parameter int VIDEO_CELLS    = 16384
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

`include "text_console_cursor_engine_defines.svh"

    localparam int REGION = VIDEO_CELLS / NUM_CONSOLES;
    localparam int AW     = $clog2(VIDEO_CELLS + SCREEN_CELLS + 1);
    localparam int CIW    = (NUM_CONSOLES > 1) ? $clog2(NUM_CONSOLES) : 1;

    logic            in_valid_reg;
    logic            in_valid_next;
    in_item_t        in_item_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    out_item_t       out_item_reg;
    logic [7:0]      attr_reg;
    logic [1:0]      shown_reg;
    logic [AW-1:0]   cursor_reg [NUM_CONSOLES];
    logic [AW-1:0]   view_reg   [NUM_CONSOLES];

    logic            in_accept;
    logic            advance;
    logic [CIW-1:0]  sel_idx;
    logic [AW-1:0]   sel_org;
    logic            state_we;
    logic [AW-1:0]   cur_next;
    logic [AW-1:0]   view_next;
    out_item_t       step_result;

    // Handshake and pipeline flow
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Console selection for the registered request
    assign sel_idx = (32'(in_item_reg.console_index) < NUM_CONSOLES)
                     ? CIW'(in_item_reg.console_index) : '0;
    assign sel_org = AW'(sel_idx) * AW'(REGION);

    tcce_step #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_CELLS   (SCREEN_CELLS),
        .NUM_CONSOLES   (NUM_CONSOLES),
        .VIDEO_CELLS    (VIDEO_CELLS),
        .AW             (AW)
    ) u_step (
        .item      (in_item_reg),
        .cur       (cursor_reg[sel_idx]),
        .view      (view_reg[sel_idx]),
        .org       (sel_org),
        .attr      (attr_reg),
        .shown     (shown_reg),
        .state_we  (state_we),
        .cur_next  (cur_next),
        .view_next (view_next),
        .result    (step_result)
    );

    // Control registers and console state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            attr_reg      <= ATTR_RESET;
            shown_reg     <= '0;
            for (int i = 0; i < NUM_CONSOLES; i++)
            begin
                cursor_reg[i] <= AW'(i * REGION);
                view_reg[i]   <= AW'(i * REGION);
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
            if (advance)
            begin
                shown_reg <= step_result.shown_console;
                if (state_we)
                begin
                    cursor_reg[sel_idx] <= cur_next;
                    view_reg[sel_idx]   <= view_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    // Checks
    `TCCE_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_accept, in_valid_reg)
    `TCCE_ASSERT_NEXT(a_advance_shows, clk, rst_n, advance, out_valid_reg)
    `TCCE_ASSERT_SAME(a_idle_write_zero, clk, rst_n,
        out_valid_reg && !out_item_reg.mem_write,
        out_item_reg.mem_cell == 14'd0 && out_item_reg.mem_attr == 8'd0)

endmodule

// ===== rtl/tcce_step.sv =====
`timescale 1ns / 1ps

// Combinational update of one console for one request.
module tcce_step
    import tcce_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_CELLS   = 2000,
    parameter int NUM_CONSOLES   = 4,
    parameter int VIDEO_CELLS    = 16384,
    parameter int AW             = 15
)
(
    input  in_item_t        item,
    input  logic [AW-1:0]   cur,
    input  logic [AW-1:0]   view,
    input  logic [AW-1:0]   org,
    input  logic [7:0]      attr,
    input  logic [1:0]      shown,
    output logic            state_we,
    output logic [AW-1:0]   cur_next,
    output logic [AW-1:0]   view_next,
    output out_item_t       result
);

    localparam int REGION       = VIDEO_CELLS / NUM_CONSOLES;
    localparam int OW           = $clog2(REGION);
    localparam int LAST_ROW_OFF = ((REGION - 1) / SCREEN_COLUMNS) * SCREEN_COLUMNS;
    localparam int TOP_OFF      = (REGION > SCREEN_CELLS) ? REGION - SCREEN_CELLS : 0;
    localparam int SHIFT        = OW + $clog2(SCREEN_COLUMNS);
    localparam longint RECIP    = ((64'd1 << SHIFT) + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS;
    localparam int RW           = OW + 2;
    localparam int PW           = OW + RW;

    logic              idx_ok;
    logic [AW-1:0]     last_cell;
    logic [OW-1:0]     offset;
    logic [PW-1:0]     prod;
    logic [OW-1:0]     row;
    logic [AW-1:0]     row_off;
    logic [AW-1:0]     nl_off;
    logic [AW-1:0]     nl_cursor;
    logic [AW-1:0]     cur_dec;
    logic [AW-1:0]     view_up;
    logic [AW-1:0]     up_limit;
    logic [AW-1:0]     view_dn_raw;
    logic [AW-1:0]     view_dn_top;
    logic [AW-1:0]     view_dn;
    logic [AW-1:0]     cur_a;
    logic              do_up;
    logic              do_down;
    logic              wr;
    logic [AW-1:0]     wr_cell;
    logic [7:0]        wch;
    logic [7:0]        wat;
    logic [1:0]        shown_n;

    assign idx_ok    = (32'(item.console_index) < NUM_CONSOLES);
    assign last_cell = org + AW'(REGION - 1);
    assign cur_dec   = cur - AW'(1);

    // Newline row: offset / columns by reciprocal multiply
    assign offset    = OW'(cur - org);
    assign prod      = PW'(offset) * PW'(RECIP);
    assign row       = OW'(prod >> SHIFT);
    assign row_off   = AW'(row) * AW'(SCREEN_COLUMNS);
    assign nl_off    = ((row_off + AW'(SCREEN_COLUMNS)) > AW'(LAST_ROW_OFF))
                       ? AW'(LAST_ROW_OFF) : row_off + AW'(SCREEN_COLUMNS);
    assign nl_cursor = org + nl_off;

    // One-row scroll candidates
    assign view_up     = (view >= org + AW'(SCREEN_COLUMNS))
                         ? view - AW'(SCREEN_COLUMNS) : org;
    assign up_limit    = view_up + AW'(SCREEN_CELLS - 1);
    assign view_dn_raw = view + AW'(SCREEN_COLUMNS);
    assign view_dn_top = org + AW'(TOP_OFF);
    assign view_dn     = (view_dn_raw > view_dn_top) ? view_dn_top : view_dn_raw;

    // Primary action of the request
    always_comb
    begin
        cur_a    = cur;
        do_up    = 1'b0;
        do_down  = 1'b0;
        wr       = 1'b0;
        wr_cell  = '0;
        wch      = '0;
        wat      = '0;
        shown_n  = shown;
        state_we = 1'b0;
        if (idx_ok)
        begin
            state_we = 1'b1;
            case (req_type_t'(item.req_type))
                REQ_WRITE_CHAR:
                begin
                    if (item.char_code == CH_NEWLINE)
                    begin
                        cur_a   = nl_cursor;
                        do_down = (nl_cursor >= view + AW'(SCREEN_CELLS));
                    end
                    else if (item.char_code == CH_BACKSPACE)
                    begin
                        if (cur > org)
                        begin
                            wr      = 1'b1;
                            wr_cell = cur_dec;
                            wch     = CH_SPACE;
                            wat     = attr;
                            cur_a   = cur_dec;
                            do_up   = (cur_dec < view);
                        end
                    end
                    else
                    begin
                        wr      = 1'b1;
                        wr_cell = cur;
                        wch     = item.char_code;
                        wat     = attr;
                        if (cur < last_cell)
                        begin
                            cur_a = cur + AW'(1);
                        end
                    end
                end
                REQ_SCROLL_UP:   do_up   = 1'b1;
                REQ_SCROLL_DOWN: do_down = 1'b1;
                REQ_SELECT:      shown_n = item.console_index;
                default:         ;
            endcase
        end
    end

    // Follow-on scroll; cursor pulled back into the view
    always_comb
    begin
        cur_next  = cur_a;
        view_next = view;
        if (do_up)
        begin
            view_next = view_up;
            if (cur_a > up_limit)
            begin
                cur_next = up_limit;
            end
        end
        else if (do_down)
        begin
            view_next = view_dn;
            if (cur_a < view_dn)
            begin
                cur_next = view_dn;
            end
        end
    end

    // Result fields
    always_comb
    begin
        result.mem_write       = wr;
        result.mem_cell        = 14'(wr_cell);
        result.mem_char        = wch;
        result.mem_attr        = wat;
        result.cursor_cell     = idx_ok ? 14'(cur_next) : 14'd0;
        result.view_start_cell = idx_ok ? 14'(view_next) : 14'd0;
        result.shown_console   = shown_n;
    end

endmodule
